>>> design/mbrtu_pkg.sv
// Shared types, constants and CRC helper for the Modbus RTU reply parser.
package mbrtu_pkg;

  localparam int MAX_FRAME_LEN = 256;
  localparam int LEN_W         = $clog2(MAX_FRAME_LEN + 1);
  localparam int HDR_DEPTH     = 7;
  localparam int MIN_FRAME_LEN = 5;
  localparam int COUNT_EXTRA   = 5;
  localparam int WRITE_LEN     = 8;

  localparam logic [15:0] CRC_START       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  CONTROL_ON_BYTE = 8'hFF;
  localparam logic [7:0]  COUNT_TEMP_HUM  = 8'd4;
  localparam logic [7:0]  COUNT_CO2       = 8'd2;

  localparam logic [3:0] OUT_TEMP_HUM  = 4'd0;
  localparam logic [3:0] OUT_CO2       = 4'd1;
  localparam logic [3:0] OUT_WRITE_ACK = 4'd2;
  localparam logic [3:0] OUT_SHORT     = 4'd3;
  localparam logic [3:0] OUT_ADDRESS   = 4'd4;
  localparam logic [3:0] OUT_CRC       = 4'd5;
  localparam logic [3:0] OUT_LENGTH    = 4'd6;
  localparam logic [3:0] OUT_FUNCTION  = 4'd7;
  localparam logic [3:0] OUT_COUNT     = 4'd8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_FUNC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_FUNC = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  outcome;
    logic [15:0] temperature_tenths;
    logic [15:0] humidity_tenths;
    logic [15:0] co2_ppm;
    logic        control_ok;
  } out_t;

  typedef logic [HDR_DEPTH-1:0][7:0] hdr_t;

  // Verdict of the frame checker and which held readings to refresh.
  typedef struct packed {
    logic [3:0] outcome;
    logic       upd_temp_hum;
    logic       upd_co2;
    logic       upd_control;
    logic       control_val;
  } chk_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/modbus_rtu_response_parser.sv
// Top level of the Modbus RTU reply parser: CRC, header capture, held readings.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_data  (rx_byte, last_byte)
//  out_    | output    | out_valid/out_stall| out_data (outcome, readings, control_ok)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte per cycle unless stalled. CRC update, header capture and the frame
// verdict are done in the accept cycle; the result request is in the output
// register in the cycle after the final byte. in_stall is raised only while a
// result is held and the output side stalls. Reset (rst_n low, synchronous)
// restarts the frame and clears the held readings; cfg_ready is always high.
module modbus_rtu_response_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mbrtu_pkg::in_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mbrtu_pkg::out_t                   out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbrtu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data
);
  import mbrtu_pkg::*;

  logic [7:0]       slave_addr_r, read_func_r, write_func_r;
  logic [15:0]      crc_r, crc_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  hdr_t             hdr_r, hdr_eff;
  logic [15:0]      temp_r, temp_nxt;
  logic [15:0]      hum_r, hum_nxt;
  logic [15:0]      co2_r, co2_nxt;
  logic             ctl_r, ctl_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;
  logic             in_acc;
  logic             frame_end;
  chk_t             chk;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign frame_end = in_acc & in_data.last_byte;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
      read_func_r  <= 8'd3;
      write_func_r <= 8'd6;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLAVE_ADDR: slave_addr_r <= cfg_data;
        CFG_READ_FUNC:  read_func_r  <= cfg_data;
        CFG_WRITE_FUNC: write_func_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // header as seen including the byte arriving now
  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      hdr_eff[i] = (cnt_r == LEN_W'(i)) ? in_data.rx_byte : hdr_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hdr_r <= hdr_eff;
    end
  end

  logic [15:0]      crc_step;
  logic [LEN_W-1:0] len_step;

  assign crc_step = crc16_byte(crc_r, in_data.rx_byte);
  assign len_step = (cnt_r < LEN_W'(MAX_FRAME_LEN)) ? cnt_r + 1'b1 : cnt_r;

  mbrtu_check u_check (
    .hdr                 (hdr_eff),
    .frame_len           (len_step),
    .crc_residue         (crc_step),
    .slave_address       (slave_addr_r),
    .read_function_code  (read_func_r),
    .write_function_code (write_func_r),
    .chk                 (chk)
  );

  always_comb begin
    crc_nxt       = crc_r;
    cnt_nxt       = cnt_r;
    temp_nxt      = temp_r;
    hum_nxt       = hum_r;
    co2_nxt       = co2_r;
    ctl_nxt       = ctl_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      crc_nxt = crc_step;
      cnt_nxt = len_step;
    end
    if (frame_end) begin
      crc_nxt = CRC_START;
      cnt_nxt = '0;
      if (chk.upd_temp_hum) begin
        temp_nxt = {hdr_eff[3], hdr_eff[4]};
        hum_nxt  = {hdr_eff[5], hdr_eff[6]};
      end
      if (chk.upd_co2) begin
        co2_nxt = {hdr_eff[3], hdr_eff[4]};
      end
      if (chk.upd_control) begin
        ctl_nxt = chk.control_val;
      end
      out_valid_nxt                 = 1'b1;
      out_data_nxt.outcome            = chk.outcome;
      out_data_nxt.temperature_tenths = temp_nxt;
      out_data_nxt.humidity_tenths    = hum_nxt;
      out_data_nxt.co2_ppm            = co2_nxt;
      out_data_nxt.control_ok         = ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_START;
      cnt_r       <= '0;
      temp_r      <= '0;
      hum_r       <= '0;
      co2_r       <= '0;
      ctl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      cnt_r       <= cnt_nxt;
      temp_r      <= temp_nxt;
      hum_r       <= hum_nxt;
      co2_r       <= co2_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

>>> design/mbrtu_check.sv
// Frame checker: judges a finished reply from its header, length and CRC residue.
module mbrtu_check (
  input  mbrtu_pkg::hdr_t              hdr,
  input  logic [mbrtu_pkg::LEN_W-1:0]  frame_len,
  input  logic [15:0]                  crc_residue,
  input  logic [7:0]                   slave_address,
  input  logic [7:0]                   read_function_code,
  input  logic [7:0]                   write_function_code,
  output mbrtu_pkg::chk_t              chk
);
  import mbrtu_pkg::*;

  logic [LEN_W-1:0] count_len;

  assign count_len = LEN_W'(hdr[2]) + LEN_W'(COUNT_EXTRA);

  always_comb begin
    chk = '0;
    if (frame_len < LEN_W'(MIN_FRAME_LEN)) begin
      chk.outcome = OUT_SHORT;
    end else if (hdr[0] != slave_address) begin
      chk.outcome = OUT_ADDRESS;
    end else if (crc_residue != 16'h0000) begin
      chk.outcome = OUT_CRC;
    end else if (hdr[1] == read_function_code) begin
      // read interpretation wins when both function codes match
      if (count_len != frame_len) begin
        chk.outcome = OUT_LENGTH;
      end else if (hdr[2] == COUNT_TEMP_HUM) begin
        chk.outcome      = OUT_TEMP_HUM;
        chk.upd_temp_hum = 1'b1;
      end else if (hdr[2] == COUNT_CO2) begin
        chk.outcome = OUT_CO2;
        chk.upd_co2 = 1'b1;
      end else begin
        chk.outcome = OUT_COUNT;
      end
    end else if (hdr[1] == write_function_code) begin
      if (frame_len != LEN_W'(WRITE_LEN)) begin
        chk.outcome = OUT_LENGTH;
      end else begin
        chk.outcome     = OUT_WRITE_ACK;
        chk.upd_control = 1'b1;
        chk.control_val = (hdr[4] == CONTROL_ON_BYTE);
      end
    end else begin
      chk.outcome = OUT_FUNCTION;
    end
  end

endmodule

>>> design/mbrtu_sva.sv
// Port-level checker for the Modbus RTU reply parser, bound to the top level.
module mbrtu_sva (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input mbrtu_pkg::in_t                    in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input mbrtu_pkg::out_t                   out_data
);
  import mbrtu_pkg::*;

  // a result request appears only after a final byte was taken
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.last_byte))
    else $error("result without accepted final byte");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  a_outcome_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.outcome <= OUT_COUNT))
    else $error("outcome code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind modbus_rtu_response_parser mbrtu_sva u_mbrtu_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> dv/tb.sv
// Testbench for the Modbus RTU reply parser: random frames checked against a predictor.
module tb;
  import mbrtu_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_BYTES = 140;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES  = 6;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  // Predicts each reply from the bytes the parser accepted and checks it.
  class reply_scoreboard;
    logic [7:0]  slave_addr;
    logic [7:0]  read_fc;
    logic [7:0]  write_fc;
    logic [15:0] crc;
    int unsigned frame_len;
    logic [7:0]  hdr [HDR_DEPTH];
    logic [15:0] temp_hold;
    logic [15:0] hum_hold;
    logic [15:0] co2_hold;
    logic        ctl_hold;
    out_t        expected_replies [$];
    int          errors;

    function new();
      slave_addr = 8'd1;
      read_fc    = 8'd3;
      write_fc   = 8'd6;
      crc        = CRC_START;
      frame_len  = 0;
      foreach (hdr[i]) hdr[i] = 8'h00;
      temp_hold  = '0;
      hum_hold   = '0;
      co2_hold   = '0;
      ctl_hold   = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == CFG_SLAVE_ADDR) slave_addr = val;
      else if (idx == CFG_READ_FUNC) read_fc = val;
      else if (idx == CFG_WRITE_FUNC) write_fc = val;
    endfunction

    // Frame verdict; refreshes the held readings on accepted frames.
    function logic [3:0] judge_frame();
      int unsigned count;
      if (frame_len < MIN_FRAME_LEN) return OUT_SHORT;
      if (hdr[0] != slave_addr) return OUT_ADDRESS;
      if (crc != 16'h0000) return OUT_CRC;
      // read wins when both function codes are equal
      if (hdr[1] == read_fc) begin
        count = hdr[2];
        if (count + COUNT_EXTRA != frame_len) return OUT_LENGTH;
        if (hdr[2] == COUNT_TEMP_HUM) begin
          temp_hold = {hdr[3], hdr[4]};
          hum_hold  = {hdr[5], hdr[6]};
          return OUT_TEMP_HUM;
        end
        if (hdr[2] == COUNT_CO2) begin
          co2_hold = {hdr[3], hdr[4]};
          return OUT_CO2;
        end
        return OUT_COUNT;
      end
      if (hdr[1] == write_fc) begin
        if (frame_len != WRITE_LEN) return OUT_LENGTH;
        ctl_hold = (hdr[4] == CONTROL_ON_BYTE);
        return OUT_WRITE_ACK;
      end
      return OUT_FUNCTION;
    endfunction

    function void take_byte(in_t d);
      out_t r;
      crc = crc16_step(crc, d.rx_byte);
      if (frame_len < HDR_DEPTH) hdr[frame_len] = d.rx_byte;
      // length saturates, CRC keeps covering every byte
      if (frame_len < MAX_FRAME_LEN) frame_len++;
      if (d.last_byte) begin
        r.outcome            = judge_frame();
        r.temperature_tenths = temp_hold;
        r.humidity_tenths    = hum_hold;
        r.co2_ppm            = co2_hold;
        r.control_ok         = ctl_hold;
        expected_replies.push_back(r);
        crc       = CRC_START;
        frame_len = 0;
      end
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (expected_replies.size() == 0) begin
        $error("reply with no frame pending: outcome %0d", got.outcome);
        errors++;
        return;
      end
      exp_r = expected_replies.pop_front();
      compare_field("outcome", exp_r.outcome, got.outcome);
      compare_field("temperature_tenths", exp_r.temperature_tenths, got.temperature_tenths);
      compare_field("humidity_tenths", exp_r.humidity_tenths, got.humidity_tenths);
      compare_field("co2_ppm", exp_r.co2_ppm, got.co2_ppm);
      compare_field("control_ok", exp_r.control_ok, got.control_ok);
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SLAVE_ADDR;
  logic [7:0]           cfg_data  = 8'h00;

  reply_scoreboard sb = new();

  logic [7:0] frame_q [$];
  logic [7:0] cur_addr = 8'd1;
  logic [7:0] cur_rfc  = 8'd3;
  logic [7:0] cur_wfc  = 8'd6;
  int         burst_left  = 0;
  int         phase_bytes = 0;
  int         idle_cycles = 0;
  bit         busy;
  bit         hold_req  = 1'b0;
  int         hold_left = 0;
  int         rx_cycle  = 0;
  int         rx_mode   = 0;

  // phase 0 runs on reset values, later phases rewrite all three registers
  logic [7:0] addr_set [NUM_PHASES] = '{8'd1, 8'd0,   8'd255, 8'd17, 8'd247, 8'd1};
  logic [7:0] rfc_set  [NUM_PHASES] = '{8'd3, 8'd0,   8'd255, 8'd4,  8'd3,   8'd3};
  logic [7:0] wfc_set  [NUM_PHASES] = '{8'd6, 8'd255, 8'd0,   8'd4,  8'd16,  8'd6};

  modbus_rtu_response_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Monitors all three channels and runs the no-progress watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      busy = 1'b0;
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        busy = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.take_byte(in_data);
        busy = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_index, cfg_data);
        busy = 1'b1;
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 250 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (rx_cycle % 3 == 0);
      endcase
    end
  end

  task automatic send_byte(in_t d);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    phase_bytes++;
  endtask

  task automatic send_frame();
    in_t d;
    foreach (frame_q[i]) begin
      d.rx_byte   = frame_q[i];
      d.last_byte = (i == frame_q.size() - 1);
      send_byte(d);
    end
  endtask

  // Appends the CRC low byte first, as on the wire.
  task automatic push_crc();
    logic [15:0] c;
    c = CRC_START;
    foreach (frame_q[i]) c = crc16_step(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic send_with_crc();
    push_crc();
    send_frame();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(logic [7:0] addr, logic [7:0] rfc, logic [7:0] wfc);
    cfg_write(CFG_SLAVE_ADDR, addr);
    cfg_write(CFG_READ_FUNC, rfc);
    cfg_write(CFG_WRITE_FUNC, wfc);
    cfg_valid <= 1'b0;
    cur_addr = addr;
    cur_rfc  = rfc;
    cur_wfc  = wfc;
  endtask

  // Mostly well-formed replies with random content; about 30% broken or noise.
  task automatic random_frame();
    int kind;
    int flaw;
    int n;
    kind = $urandom_range(0, 99);
    flaw = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 7) : 0;
    frame_q = '{cur_addr, cur_rfc};
    if (kind >= 45 && kind < 60) begin
      frame_q[1] = cur_wfc;
      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom));
      frame_q.push_back($urandom_range(0, 1) ? CONTROL_ON_BYTE : 8'($urandom));
      frame_q.push_back(8'($urandom));
    end else begin
      if (kind < 25) n = COUNT_TEMP_HUM;
      else if (kind < 45) n = COUNT_CO2;
      else if (kind == 60) n = $urandom_range(0, 1) ? 251 : $urandom_range(240, 255);
      else n = $urandom_range(0, 12);
      frame_q.push_back(8'(n));
      // overlong frame: the saturated length decides the count check
      if (kind == 60) n = $urandom_range(248, 300);
      repeat (n) frame_q.push_back(8'($urandom));
    end
    case (flaw)
      1: frame_q.pop_back();
      2: frame_q.push_back(8'($urandom));
      3: frame_q[1] = 8'($urandom);
      default: ;
    endcase
    push_crc();
    case (flaw)
      4: begin
        n = $urandom_range(0, frame_q.size() - 1);
        frame_q[n] = frame_q[n] ^ 8'(1 << $urandom_range(0, 7));
      end
      5: frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
      6: begin
        frame_q.delete();
        repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      end
      7: begin
        frame_q.delete();
        repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      end
      default: ;
    endcase
    send_frame();
  endtask

  task automatic directed_frames();
    frame_q = '{8'h01, 8'h03, 8'h04, 8'h00, 8'hFF, 8'h02, 8'h58};
    send_with_crc();
    frame_q = '{8'h01, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_with_crc();
    frame_q = '{8'h01, 8'h03, 8'h02, 8'hFF, 8'hFF};
    send_with_crc();
    frame_q = '{8'h01, 8'h06, 8'h00, 8'h10, 8'hFF, 8'h00};
    send_with_crc();
    frame_q = '{8'h01, 8'h06, 8'h00, 8'h10, 8'h00, 8'h00};
    send_with_crc();
    // too short, one byte and four bytes
    frame_q = '{8'h01};
    send_frame();
    frame_q = '{8'h01, 8'h03, 8'h02, 8'h00};
    send_frame();
    frame_q = '{8'h02, 8'h03, 8'h02, 8'h00, 8'h10};
    send_with_crc();
    // bad CRC
    frame_q = '{8'h01, 8'h03, 8'h04, 8'h12, 8'h34, 8'h56, 8'h78};
    push_crc();
    frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'h80;
    send_frame();
    // read count disagrees with length; write echo one byte short
    frame_q = '{8'h01, 8'h03, 8'h04, 8'hAA, 8'hBB};
    send_with_crc();
    frame_q = '{8'h01, 8'h06, 8'h00, 8'h10, 8'hFF};
    send_with_crc();
    frame_q = '{8'h01, 8'h10, 8'h00, 8'h01};
    send_with_crc();
    // count of zero, then other counts
    frame_q = '{8'h01, 8'h03, 8'h00};
    send_with_crc();
    frame_q = '{8'h01, 8'h03, 8'h01, 8'h5A};
    send_with_crc();
    // frame exactly at the saturation limit, then well past it
    frame_q = '{8'h01, 8'h03, 8'd251};
    repeat (251) frame_q.push_back(8'($urandom));
    send_with_crc();
    frame_q = '{8'h01, 8'h03, 8'd251};
    repeat (295) frame_q.push_back(8'($urandom));
    send_with_crc();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_frames();
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p > 0) set_config(addr_set[p], rfc_set[p], wfc_set[p]);
      if (p == 2) hold_req = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) random_frame();
    end
    wait_idle();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
design/mbrtu_pkg.sv
design/mbrtu_check.sv
design/modbus_rtu_response_parser.sv
design/mbrtu_sva.sv
dv/tb.sv
